// ===== rtl/ssd_pkg.sv =====
// ============================================================================
// ssd_pkg - shared types and constants for the segment distance core
// Fixed widths of the datapath, the job record handed from front to back.
// ============================================================================
`default_nettype none

package ssd_pkg;

    localparam int CW        = 32;            // input coordinate, Q16.16
    localparam int DW        = CW + 1;        // endpoint difference
    localparam int PW        = 2 * DW;        // one coordinate product
    localparam int DOTW      = PW + 2;        // dot product of 3-vectors
    localparam int NW        = 140;           // determinant and numerators
    localparam int FRAC_BITS = 36;            // parameter fraction bits
    localparam int QW        = FRAC_BITS + 1; // parameter in [0, 1.0]
    localparam int CMPW      = 73;            // closest-vector component
    localparam int SQW       = 148;           // squared length
    localparam int ROOTW     = 36;            // square root result
    localparam int DISTW     = 34;            // saturated distance

    typedef logic signed [CW-1:0]   coord_t;
    typedef coord_t      [2:0]      point_t;
    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [NW-1:0]   num_t;
    typedef logic        [QW-1:0]   frac_t;

    typedef struct packed {
        diff_t [2:0] u;
        diff_t [2:0] v;
        diff_t [2:0] w;
    } geo_t;

    typedef struct packed {
        num_t s_num;
        num_t s_den;
        num_t t_num;
        num_t t_den;
        geo_t geo;
    } job_t;

    localparam frac_t            FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DISTW-1:0] DIST_MAX = {DISTW{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/ssd_mul.sv =====
// ============================================================================
// ssd_mul - two-stage signed multiplier
// Splits both operands into a low and a high limb; partial products are
// registered, then summed in the second stage.
// ============================================================================
`default_nettype none

module ssd_mul #(
    parameter int W = 68,
    parameter int H = 34
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic signed [2*W-1:0]      p
);

    localparam int HW = W - H;

    typedef logic signed [2*W-1:0] prod_t;

    logic signed [H:0]      a_lo, b_lo;
    logic signed [HW-1:0]   a_hi, b_hi;
    logic signed [2*HW-1:0] hh_reg;
    logic signed [HW+H:0]   hl_reg, lh_reg;
    logic signed [2*H+1:0]  ll_reg;
    prod_t                  p_reg;

    assign a_lo = $signed({1'b0, a[H-1:0]});
    assign b_lo = $signed({1'b0, b[H-1:0]});
    assign a_hi = $signed(a[W-1:H]);
    assign b_hi = $signed(b[W-1:H]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * b_lo;
            lh_reg <= a_lo * b_hi;
            ll_reg <= a_lo * b_lo;
            p_reg  <= (prod_t'(hh_reg) <<< (2 * H))
                    + ((prod_t'(hl_reg) + prod_t'(lh_reg)) <<< H)
                    + prod_t'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/ssd_frac.sv =====
// ============================================================================
// ssd_frac - pipelined fraction unit
// floor(num * 2^36 / den) limited to [0, 1.0], one quotient bit per stage.
// ============================================================================
`default_nettype none

module ssd_frac (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire ssd_pkg::num_t num,
    input  wire ssd_pkg::num_t den,
    output ssd_pkg::frac_t    q
);

    localparam int FB = ssd_pkg::FRAC_BITS;
    localparam int RW = ssd_pkg::NW + 1;

    typedef logic [RW-1:0] rem_t;

    rem_t          r_reg    [0:FB];
    rem_t          den_reg  [0:FB];
    logic [FB-1:0] q_reg    [0:FB];
    logic          spec_reg [0:FB];
    logic          one_reg  [0:FB];

    logic num_pos, den_pos, num_ge;

    assign num_pos = !num[ssd_pkg::NW-1] && (num != '0);
    assign den_pos = !den[ssd_pkg::NW-1] && (den != '0);
    assign num_ge  = (num >= den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= rem_t'($unsigned(num));
            den_reg[0]  <= rem_t'($unsigned(den));
            q_reg[0]    <= '0;
            spec_reg[0] <= !num_pos || !den_pos || num_ge;
            one_reg[0]  <= num_pos && den_pos && num_ge;
        end
    end

    // restoring division, one bit per stage
    for (genvar k = 1; k <= FB; k++)
    begin : g_stage
        rem_t r2;
        logic ge;

        assign r2 = r_reg[k-1] << 1;
        assign ge = (r2 >= den_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= ge ? (r2 - den_reg[k-1]) : r2;
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][FB-2:0], ge};
                spec_reg[k] <= spec_reg[k-1];
                one_reg[k]  <= one_reg[k-1];
            end
        end
    end

    assign q = spec_reg[FB] ? (one_reg[FB] ? ssd_pkg::FRAC_ONE : '0)
                            : {1'b0, q_reg[FB]};

endmodule

`default_nettype wire

// ===== rtl/ssd_front.sv =====
// ============================================================================
// ssd_front - front pipeline
// Differences, dot products, determinant and the clamping of both
// parameters to exact fractions; hands one job per beat to the queue.
// ============================================================================
`default_nettype none

module ssd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ssd_pkg::point_t a_start,
    input  wire ssd_pkg::point_t a_end,
    input  wire ssd_pkg::point_t b_start,
    input  wire ssd_pkg::point_t b_end,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output ssd_pkg::job_t        job
);

    localparam int NS   = 8;
    localparam int NW   = ssd_pkg::NW;
    localparam int DOTW = ssd_pkg::DOTW;

    typedef logic signed [ssd_pkg::PW-1:0] prod_t;
    typedef logic signed [DOTW-1:0]        dot_t;
    typedef logic signed [2*DOTW-1:0]      wide_t;

    logic                 en;
    logic [NS:1]          v_reg;
    ssd_pkg::geo_t        geo_in;
    ssd_pkg::geo_t        geo_reg [1:NS];
    prod_t                prod_reg [15];
    dot_t                 dot_reg [5];
    dot_t                 dot4_reg [5];
    dot_t                 dot5_reg [5];
    wide_t                ac, bb, be, cd, ae, bd;
    ssd_pkg::num_t        det_reg, sn0_reg, tn0_reg, a6_reg, c6_reg, e6_reg;
    ssd_pkg::num_t        nd6_reg, ndb6_reg, ebp6_reg;
    ssd_pkg::num_t        sn7, sd7, tn7, td7;
    ssd_pkg::num_t        sn7_reg, sd7_reg, tn7_reg, td7_reg, a7_reg, nd7_reg, ndb7_reg;
    ssd_pkg::num_t        sn8, sd8, tn8, td8;
    ssd_pkg::job_t        job_reg;

    assign en       = !(v_reg[NS] && !job_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-1:1], in_valid};
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            geo_in.u[c] = ssd_pkg::diff_t'($signed(a_end[c]))
                        - ssd_pkg::diff_t'($signed(a_start[c]));
            geo_in.v[c] = ssd_pkg::diff_t'($signed(b_end[c]))
                        - ssd_pkg::diff_t'($signed(b_start[c]));
            geo_in.w[c] = ssd_pkg::diff_t'($signed(a_start[c]))
                        - ssd_pkg::diff_t'($signed(b_start[c]));
        end
    end

    // products: uu, uv, vv, uw, vw; then dots a, b, c, d, e
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[1] <= geo_in;
            for (int k = 2; k <= NS; k++)
                geo_reg[k] <= geo_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c]      <= $signed(geo_reg[1].u[c]) * $signed(geo_reg[1].u[c]);
                prod_reg[3 + c]  <= $signed(geo_reg[1].u[c]) * $signed(geo_reg[1].v[c]);
                prod_reg[6 + c]  <= $signed(geo_reg[1].v[c]) * $signed(geo_reg[1].v[c]);
                prod_reg[9 + c]  <= $signed(geo_reg[1].u[c]) * $signed(geo_reg[1].w[c]);
                prod_reg[12 + c] <= $signed(geo_reg[1].v[c]) * $signed(geo_reg[1].w[c]);
            end
            for (int k = 0; k < 5; k++)
            begin
                dot_reg[k]  <= dot_t'(prod_reg[3*k]) + dot_t'(prod_reg[3*k + 1])
                             + dot_t'(prod_reg[3*k + 2]);
                dot4_reg[k] <= dot_reg[k];
                dot5_reg[k] <= dot4_reg[k];
            end
        end
    end

    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_ac
        (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[2]), .p(ac));
    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_bb
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[1]), .p(bb));
    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_be
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[4]), .p(be));
    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_cd
        (.clk(clk), .en(en), .a(dot_reg[2]), .b(dot_reg[3]), .p(cd));
    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_ae
        (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[4]), .p(ae));
    ssd_mul #(.W(DOTW), .H(DOTW / 2)) u_mul_bd
        (.clk(clk), .en(en), .a(dot_reg[1]), .b(dot_reg[3]), .p(bd));

    // determinant and raw numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= ssd_pkg::num_t'(ac) - ssd_pkg::num_t'(bb);
            sn0_reg  <= ssd_pkg::num_t'(be) - ssd_pkg::num_t'(cd);
            tn0_reg  <= ssd_pkg::num_t'(ae) - ssd_pkg::num_t'(bd);
            a6_reg   <= ssd_pkg::num_t'(dot5_reg[0]);
            c6_reg   <= ssd_pkg::num_t'(dot5_reg[2]);
            e6_reg   <= ssd_pkg::num_t'(dot5_reg[4]);
            nd6_reg  <= -ssd_pkg::num_t'(dot5_reg[3]);
            ndb6_reg <= ssd_pkg::num_t'(dot5_reg[1]) - ssd_pkg::num_t'(dot5_reg[3]);
            ebp6_reg <= ssd_pkg::num_t'(dot5_reg[4]) + ssd_pkg::num_t'(dot5_reg[1]);
        end
    end

    // clamp s, re-solve t
    always_comb
    begin
        sn7 = sn0_reg;
        sd7 = det_reg;
        tn7 = tn0_reg;
        td7 = det_reg;
        priority if (det_reg == '0)
        begin
            sn7 = '0;
            sd7 = ssd_pkg::num_t'(1);
            tn7 = e6_reg;
            td7 = c6_reg;
        end
        else if (sn0_reg[NW-1])
        begin
            sn7 = '0;
            tn7 = e6_reg;
            td7 = c6_reg;
        end
        else if (sn0_reg > det_reg)
        begin
            sn7 = det_reg;
            tn7 = ebp6_reg;
            td7 = c6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn7_reg  <= sn7;
            sd7_reg  <= sd7;
            tn7_reg  <= tn7;
            td7_reg  <= td7;
            a7_reg   <= a6_reg;
            nd7_reg  <= nd6_reg;
            ndb7_reg <= ndb6_reg;
        end
    end

    // clamp t, re-solve s
    always_comb
    begin
        sn8 = sn7_reg;
        sd8 = sd7_reg;
        tn8 = tn7_reg;
        td8 = td7_reg;
        priority if (tn7_reg[NW-1])
        begin
            tn8 = '0;
            priority if (nd7_reg[NW-1])
                sn8 = '0;
            else if (nd7_reg > a7_reg)
                sn8 = sd7_reg;
            else
            begin
                sn8 = nd7_reg;
                sd8 = a7_reg;
            end
        end
        else if (tn7_reg > td7_reg)
        begin
            tn8 = td7_reg;
            priority if (ndb7_reg[NW-1])
                sn8 = '0;
            else if (ndb7_reg > a7_reg)
                sn8 = sd7_reg;
            else
            begin
                sn8 = ndb7_reg;
                sd8 = a7_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_reg.s_num <= sn8;
            job_reg.s_den <= sd8;
            job_reg.t_num <= tn8;
            job_reg.t_den <= td8;
            job_reg.geo   <= geo_reg[NS-1];
        end
    end

    assign job_valid = v_reg[NS];
    assign job       = job_reg;

endmodule

`default_nettype wire

// ===== rtl/ssd_fifo.sv =====
// ============================================================================
// ssd_fifo - job queue between front and back
// Small register queue; full and empty flags from an occupancy count.
// ============================================================================
`default_nettype none

module ssd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ssd_pkg::job_t din,
    output logic               full,
    input  wire logic          pop,
    output ssd_pkg::job_t      dout,
    output logic               empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int NC = $clog2(DEPTH + 1);

    ssd_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NC-1:0] count_reg, count_next;

    assign full  = (count_reg == NC'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

// ===== rtl/ssd_back.sv =====
// ============================================================================
// ssd_back - back pipeline
// Divides out both parameters, forms the closest vector, its squared
// length, and the integer square root; ends in the output register.
// ============================================================================
`default_nettype none

module ssd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire ssd_pkg::job_t                 job,
    output logic                               job_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ssd_pkg::DISTW-1:0]          distance
);

    localparam int FB    = ssd_pkg::FRAC_BITS;
    localparam int QW    = ssd_pkg::QW;
    localparam int DW    = ssd_pkg::DW;
    localparam int CMPW  = ssd_pkg::CMPW;
    localparam int SQW   = ssd_pkg::SQW;
    localparam int RTW   = ssd_pkg::ROOTW;
    localparam int DISTW = ssd_pkg::DISTW;
    localparam int REMW  = RTW + 2;
    localparam int QRW   = 2 * RTW;
    localparam int QSH   = 2 * FB;
    localparam int NSTG  = (FB + 1) + 5 + RTW + 1;

    typedef logic signed [QW+DW:0]   scl_t;
    typedef logic signed [CMPW-1:0]  cmp_t;
    typedef logic signed [2*CMPW-1:0] sq_t;
    typedef logic signed [SQW-1:0]   sum_t;

    logic              en;
    logic [NSTG-1:0]   vb_reg;
    ssd_pkg::frac_t    sc, tc;
    ssd_pkg::geo_t     geo_reg [0:FB];
    scl_t              scu_reg [3];
    scl_t              tcv_reg [3];
    ssd_pkg::diff_t    w1_reg  [3];
    cmp_t              comp_reg [3];
    sq_t               sq [3];
    sum_t              s_reg;
    logic [RTW-1:0]    root_reg [0:RTW-1];
    logic [REMW-1:0]   rem_reg  [0:RTW-1];
    logic [QRW-1:0]    qv_reg   [0:RTW-1];
    logic [DISTW-1:0]  dist_reg;
    logic [RTW-1:0]    root_f;

    assign en        = !vb_reg[NSTG-1] || out_ready;
    assign job_pop   = en && job_valid;
    assign out_valid = vb_reg[NSTG-1];
    assign distance  = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= '0;
        end
        else if (en)
        begin
            vb_reg <= {vb_reg[NSTG-2:0], job_valid};
        end
    end

    ssd_frac u_frac_s (.clk(clk), .en(en), .num(job.s_num), .den(job.s_den), .q(sc));
    ssd_frac u_frac_t (.clk(clk), .en(en), .num(job.t_num), .den(job.t_den), .q(tc));

    // geometry rides alongside the dividers, then scaled by s and t
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= job.geo;
            for (int k = 1; k <= FB; k++)
                geo_reg[k] <= geo_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                scu_reg[c]  <= $signed({1'b0, sc}) * $signed(geo_reg[FB].u[c]);
                tcv_reg[c]  <= $signed({1'b0, tc}) * $signed(geo_reg[FB].v[c]);
                w1_reg[c]   <= $signed(geo_reg[FB].w[c]);
                comp_reg[c] <= (cmp_t'(w1_reg[c]) <<< FB) + cmp_t'(scu_reg[c])
                             - cmp_t'(tcv_reg[c]);
            end
            s_reg <= sum_t'(sq[0]) + sum_t'(sq[1]) + sum_t'(sq[2]);
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_sq
        ssd_mul #(.W(CMPW), .H(CMPW / 2 + 1)) u_mul_sq
            (.clk(clk), .en(en), .a(comp_reg[c]), .b(comp_reg[c]), .p(sq[c]));
    end

    // digit-by-digit square root of the length at Q16.16 scale
    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        logic [REMW-1:0] rem_src;
        logic [RTW-1:0]  root_src;
        logic [QRW-1:0]  q_src;
        logic [REMW+1:0] rem_sh;
        logic [REMW+1:0] trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_src  = '0;
            assign root_src = '0;
            assign q_src    = s_reg[QSH+QRW-1:QSH];
        end
        else
        begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign q_src    = qv_reg[k-1];
        end

        assign rem_sh = {rem_src, q_src[2*(RTW-1-k)+1 -: 2]};
        assign trial  = {2'b00, root_src, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
                root_reg[k] <= {root_src[RTW-2:0], ge};
                qv_reg[k]   <= q_src;
            end
        end
    end

    assign root_f = root_reg[RTW-1];

    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= (root_f > RTW'(ssd_pkg::DIST_MAX)) ? ssd_pkg::DIST_MAX
                                                           : root_f[DISTW-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/segment_segment_distance_3d_core.sv =====
// ============================================================================
// segment_segment_distance_3d_core - closest distance of two 3D segments
// Q16.16 endpoints in, saturating Q18.16 distance out, one beat per pair.
// ============================================================================
// Pipeline: 8 front stages, the job queue, 79 back stages incl. output register.
// Throughput: one pair per cycle while the output is not stalled; every stage is a register slice.
// Reset: rst_n async, clears only valid bits, queue pointers and queue count.
`default_nettype none

module segment_segment_distance_3d_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [31:0]          a_start_x,
    input  wire logic signed [31:0]          a_start_y,
    input  wire logic signed [31:0]          a_start_z,
    input  wire logic signed [31:0]          a_end_x,
    input  wire logic signed [31:0]          a_end_y,
    input  wire logic signed [31:0]          a_end_z,
    input  wire logic signed [31:0]          b_start_x,
    input  wire logic signed [31:0]          b_start_y,
    input  wire logic signed [31:0]          b_start_z,
    input  wire logic signed [31:0]          b_end_x,
    input  wire logic signed [31:0]          b_end_y,
    input  wire logic signed [31:0]          b_end_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [33:0]                      distance
);

    // Front: u = a_end - a_start, v = b_end - b_start, w = a_start - b_start,
    // the five dots, D = ac - b^2, and the clamped exact fractions for s, t.
    // Parallel case (D == 0) takes s = 0. Each part stalls on its own; the
    // queue absorbs the slip between them.

    ssd_pkg::point_t a_start, a_end, b_start, b_end;
    ssd_pkg::job_t   job_f, job_q;
    logic            job_valid_f, fifo_full, fifo_empty, job_pop;

    assign a_start = {a_start_z, a_start_y, a_start_x};
    assign a_end   = {a_end_z,   a_end_y,   a_end_x};
    assign b_start = {b_start_z, b_start_y, b_start_x};
    assign b_end   = {b_end_z,   b_end_y,   b_end_x};

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_start   (a_start),
        .a_end     (a_end),
        .b_start   (b_start),
        .b_end     (b_end),
        .job_valid (job_valid_f),
        .job_ready (!fifo_full),
        .job       (job_f)
    );

    // a beat leaves the front only when the queue has room
    ssd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid_f && !fifo_full),
        .din   (job_f),
        .full  (fifo_full),
        .pop   (job_pop),
        .dout  (job_q),
        .empty (fifo_empty)
    );

    // Back: 37-stage fraction dividers, closest vector, squared length,
    // 36-stage square root, saturate to 34 bits in the output register.
    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!fifo_empty),
        .job       (job_q),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

endmodule

`default_nettype wire

// ===== rtl/ssd_checker.sv =====
// ============================================================================
// ssd_checker - port-level checks for the segment distance core
// Handshake holds, reset state, and the cause of input back-pressure.
// ============================================================================
`default_nettype none

module ssd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [33:0] distance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("output beat dropped or changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid withdrawn before accept");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid out of reset");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

endmodule

bind segment_segment_distance_3d_core ssd_checker u_ssd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance)
);

`default_nettype wire

// ===== tb/segment_segment_distance_3d_core_test.sv =====
// ============================================================================
// segment_segment_distance_3d_core_test - closest segment distance checker
// Drives segment pairs through the core under several idle and stall mixes,
// predicts each distance with exact wide integer math and compares in order.
// ============================================================================
`default_nettype none

module segment_segment_distance_3d_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Wide signed scratch type: every intermediate fits well inside 256 bits
    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        ssd_pkg::point_t a_s;
        ssd_pkg::point_t a_e;
        ssd_pkg::point_t b_s;
        ssd_pkg::point_t b_e;
    } seg_pair_t;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 200;   // final wait, longer than the core latency

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    ssd_pkg::point_t a_s, a_e, b_s, b_e;
    logic            out_valid;
    logic            out_ready;
    logic [33:0]     distance;

    logic [33:0] pending_dist[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          beats_sent;
    int          beats_checked;
    int          cycles;
    int          saturated_seen;

    segment_segment_distance_3d_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_start_x (a_s[0]),
        .a_start_y (a_s[1]),
        .a_start_z (a_s[2]),
        .a_end_x   (a_e[0]),
        .a_end_y   (a_e[1]),
        .a_end_z   (a_e[2]),
        .b_start_x (b_s[0]),
        .b_start_y (b_s[1]),
        .b_start_z (b_s[2]),
        .b_end_x   (b_e[0]),
        .b_end_y   (b_e[1]),
        .b_end_z   (b_e[2]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Distance predictor
    // ------------------------------------------------------------------

    // floor(num * 2^36 / den) held to [0, 1.0]; non-positive terms give 0
    function automatic ssd_pkg::frac_t param_of(input wide_t num, input wide_t den);
        if (num <= 0 || den <= 0)
            return '0;
        if (num >= den)
            return ssd_pkg::FRAC_ONE;
        return ssd_pkg::frac_t'((num <<< ssd_pkg::FRAC_BITS) / den);
    endfunction

    function automatic logic [33:0] seg_distance(input seg_pair_t p);
        wide_t u[3], v[3], w[3];
        wide_t da, db, dc, dd, de, det, s_n, s_d, t_n, t_d, nd, ndb, sq_len, comp;
        wide_t scw, tcw, sq;
        ssd_pkg::frac_t sc, tc;
        logic [35:0] root;
        logic [35:0] cand;
        root = '0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = wide_t'(p.a_e[i]) - wide_t'(p.a_s[i]);
            v[i] = wide_t'(p.b_e[i]) - wide_t'(p.b_s[i]);
            w[i] = wide_t'(p.a_s[i]) - wide_t'(p.b_s[i]);
        end
        da = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        db = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        dc = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        dd = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        de = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
        det = da*dc - db*db;
        s_d = det;
        t_d = det;
        if (det == 0)
        begin
            // parallel: pin s to the start of A, project onto B
            s_n = 0;
            s_d = 1;
            t_n = de;
            t_d = dc;
        end
        else
        begin
            s_n = db*de - dc*dd;
            t_n = da*de - db*dd;
            if (s_n < 0)
            begin
                s_n = 0;
                t_n = de;
                t_d = dc;
            end
            else if (s_n > s_d)
            begin
                s_n = s_d;
                t_n = de + db;
                t_d = dc;
            end
        end
        nd  = -dd;
        ndb = nd + db;
        // t clamped at either end of B: re-solve s on A
        if (t_n < 0)
        begin
            t_n = 0;
            if (nd < 0)
                s_n = 0;
            else if (nd > da)
                s_n = s_d;
            else
            begin
                s_n = nd;
                s_d = da;
            end
        end
        else if (t_n > t_d)
        begin
            t_n = t_d;
            if (ndb < 0)
                s_n = 0;
            else if (ndb > da)
                s_n = s_d;
            else
            begin
                s_n = ndb;
                s_d = da;
            end
        end
        sc  = param_of(s_n, s_d);
        tc  = param_of(t_n, t_d);
        scw = wide_t'({1'b0, sc});
        tcw = wide_t'({1'b0, tc});
        sq_len = 0;
        for (int i = 0; i < 3; i++)
        begin
            comp   = (w[i] <<< ssd_pkg::FRAC_BITS) + scw*u[i] - tcw*v[i];
            sq_len = sq_len + comp*comp;
        end
        // integer sqrt at Q16.16 scale, truncated
        for (int bitn = 35; bitn >= 0; bitn--)
        begin
            cand = root | (36'd1 << bitn);
            sq   = (wide_t'({1'b0, cand}) * wide_t'({1'b0, cand}))
                   <<< (2*ssd_pkg::FRAC_BITS);
            if (sq <= sq_len)
                root = cand;
        end
        if (root > 36'(ssd_pkg::DIST_MAX))
            return ssd_pkg::DIST_MAX;
        return root[33:0];
    endfunction

    // ------------------------------------------------------------------
    // Beat driver, result checker, watchdog
    // ------------------------------------------------------------------

    task automatic send_pair(input seg_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        a_s <= p.a_s;
        a_e <= p.a_e;
        b_s <= p.b_s;
        b_e <= p.b_e;
        in_valid <= 1'b1;
        pending_dist = {pending_dist, seg_distance(p)};
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    // Hold off until every outstanding distance has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dist.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        logic [33:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: distance=%0d", distance);
            end
            else
            begin
                want = pending_dist.pop_front();
                if (distance !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance mismatch: expected %0d actual %0d", want, distance);
                end
                if (want == ssd_pkg::DIST_MAX)
                    saturated_seen++;
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic ssd_pkg::coord_t near_coord();
        return ssd_pkg::coord_t'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    function automatic ssd_pkg::point_t rand_point(input bit full);
        ssd_pkg::point_t pt;
        for (int i = 0; i < 3; i++)
            pt[i] = full ? ssd_pkg::coord_t'($urandom) : near_coord();
        return pt;
    endfunction

    function automatic seg_pair_t same_coord_pair(input ssd_pkg::coord_t c);
        seg_pair_t p;
        for (int i = 0; i < 3; i++)
        begin
            p.a_s[i] = c;
            p.a_e[i] = c;
            p.b_s[i] = c;
            p.b_e[i] = c;
        end
        return p;
    endfunction

    function automatic ssd_pkg::point_t pt3(input int x, input int y, input int z);
        ssd_pkg::point_t pt;
        pt[0] = ssd_pkg::coord_t'(x <<< 16);
        pt[1] = ssd_pkg::coord_t'(y <<< 16);
        pt[2] = ssd_pkg::coord_t'(z <<< 16);
        return pt;
    endfunction

    // Mixed random pair: general, parallel, degenerate, shared endpoint, full range
    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int        kind;
        int        k;
        kind  = $urandom_range(9);
        p.a_s = rand_point(0);
        p.a_e = rand_point(0);
        p.b_s = rand_point(0);
        p.b_e = rand_point(0);
        case (kind)
            0, 1:
            begin
                p.a_s = rand_point(1);
                p.a_e = rand_point(1);
                p.b_s = rand_point(1);
                p.b_e = rand_point(1);
            end
            2:
            begin
                // B parallel to A, scaled by a small integer
                k = $signed($urandom_range(0, 6)) - 3;
                for (int i = 0; i < 3; i++)
                    p.b_e[i] = p.b_s[i] + ssd_pkg::coord_t'(k * (p.a_e[i] - p.a_s[i]));
            end
            3:
                p.a_e = p.a_s;
            4:
                p.b_e = p.b_s;
            5:
                p.b_s = p.a_e;
            6:
            begin
                // mixed full-range and near endpoints
                p.a_s = rand_point(1);
                p.b_e = rand_point(1);
            end
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed;
        seg_pair_t p;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(same_coord_pair('0));
        send_pair(same_coord_pair(ssd_pkg::coord_t'(32'h7fff_ffff)));
        send_pair(same_coord_pair(ssd_pkg::coord_t'(32'h8000_0000)));
        send_pair(same_coord_pair(ssd_pkg::coord_t'(32'hffff_ffff)));
        // opposite corners of the range: longest distance, still below saturation
        p = same_coord_pair(ssd_pkg::coord_t'(32'h8000_0000));
        for (int i = 0; i < 3; i++)
        begin
            p.b_s[i] = ssd_pkg::coord_t'(32'h7fff_ffff);
            p.b_e[i] = ssd_pkg::coord_t'(32'h7fff_ffff);
        end
        send_pair(p);
        p.a_e = p.b_e;
        send_pair(p);
        // crossing segments, interior solution
        send_pair('{pt3(-1, 0, 0), pt3(1, 0, 0), pt3(0, -1, 2), pt3(0, 1, 2)});
        // skew, s beyond 1
        send_pair('{pt3(0, 0, 0), pt3(1, 0, 0), pt3(5, -1, 3), pt3(5, 1, 3)});
        // skew, s below 0
        send_pair('{pt3(0, 0, 0), pt3(1, 0, 0), pt3(-4, -1, 3), pt3(-4, 1, 3)});
        // t below 0 branches
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(2, 3, 1), pt3(2, 9, 1)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(-3, 3, 1), pt3(-3, 9, 1)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(8, 3, 1), pt3(9, 9, 1)});
        // t above 1 branches
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(2, 9, 1), pt3(2, 3, 1)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(-6, 9, 1), pt3(-5, 3, 1)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(9, 9, 1), pt3(8, 3, 1)});
        // parallel, overlapping and disjoint, opposite direction
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(1, 2, 0), pt3(3, 2, 0)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(7, 2, 0), pt3(9, 2, 0)});
        send_pair('{pt3(0, 0, 0), pt3(4, 0, 0), pt3(-1, 2, 0), pt3(-5, 2, 0)});
        // collinear
        send_pair('{pt3(0, 0, 0), pt3(4, 4, 4), pt3(6, 6, 6), pt3(9, 9, 9)});
        // zero-length segments
        send_pair('{pt3(1, 2, 3), pt3(1, 2, 3), pt3(0, 0, 0), pt3(5, 0, 0)});
        send_pair('{pt3(0, 0, 0), pt3(5, 0, 0), pt3(1, 2, 3), pt3(1, 2, 3)});
        send_pair('{pt3(1, 2, 3), pt3(1, 2, 3), pt3(-4, 6, 3), pt3(-4, 6, 3)});
        // shared endpoint
        send_pair('{pt3(0, 0, 0), pt3(3, 1, 0), pt3(3, 1, 0), pt3(7, -2, 5)});
        drain();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            // stretches with no idling or stalling inside a phase
            if ((n % 100) >= 80)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = idle_pct;
                recv_stall_pct = stall_pct;
            end
            send_pair(rand_pair());
        end
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        a_s            = '0;
        a_e            = '0;
        b_s            = '0;
        b_e            = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        cycles         = 0;
        saturated_seen = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400, 0, 0);
        test_random(400, 60, 0);
        test_random(400, 0, 60);
        test_random(400, 9, 9);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_dist.size() != 0)
        begin
            mismatches++;
            $display("%0d distances never arrived", pending_dist.size());
        end
        $display("covered %0d segment pairs (%0d saturated) over four idle/stall mixes",
                 beats_sent, saturated_seen);
        $display("checked %0d distance beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ssd_pkg.sv
rtl/ssd_mul.sv
rtl/ssd_frac.sv
rtl/ssd_front.sv
rtl/ssd_fifo.sv
rtl/ssd_back.sv
rtl/segment_segment_distance_3d_core.sv
rtl/ssd_checker.sv
tb/segment_segment_distance_3d_core_test.sv
